// ----- rtl/core/tty_line_input_discipline_assert.svh -----
// ----------------------------------------------------------------------------
// TTY line input discipline assertion macros
// Shared property forms for the port checker; clk and arst_n in scope.
// ----------------------------------------------------------------------------
`ifndef TTY_LINE_INPUT_DISCIPLINE_ASSERT_SVH
`define TTY_LINE_INPUT_DISCIPLINE_ASSERT_SVH

// same-cycle implication
`define TLI_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TLI_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/tli_pkg.sv -----
// ----------------------------------------------------------------------------
// TTY line input discipline package
// Item types, command and status codes, character constants.
// ----------------------------------------------------------------------------
package tli_pkg;

	localparam logic [1:0] CMD_KEY     = 2'd0;
	localparam logic [1:0] CMD_READ    = 2'd1;
	localparam logic [1:0] CMD_SERVICE = 2'd2;

	localparam logic [2:0] STS_QUEUED    = 3'd0;
	localparam logic [2:0] STS_DROPPED   = 3'd1;
	localparam logic [2:0] STS_IGNORED   = 3'd2;
	localparam logic [2:0] STS_ARMED     = 3'd3;
	localparam logic [2:0] STS_EMPTY     = 3'd4;
	localparam logic [2:0] STS_CONSUMED  = 3'd5;
	localparam logic [2:0] STS_DISCARDED = 3'd6;

	localparam logic REG_ENTER     = 1'b0;
	localparam logic REG_BACKSPACE = 1'b1;

	localparam logic [8:0] ENTER_RESET     = 9'd284;
	localparam logic [8:0] BACKSPACE_RESET = 9'd270;
	localparam int         SPECIAL_BIT     = 8;

	localparam logic [7:0] CH_NEWLINE     = 8'h0A;
	localparam logic [7:0] CH_BACKSPACE   = 8'h08;
	localparam logic [7:0] CH_FIRST_PRINT = 8'h20;
	localparam logic [7:0] CH_LAST_PRINT  = 8'h7E;

	typedef enum logic {
		S_IDLE,
		S_POP
	} state_t;

	typedef struct packed {
		logic [1:0]  command;
		logic [8:0]  key_code;
		logic [11:0] request_count;
		logic [7:0]  requester;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic        echo_valid;
		logic [7:0]  char_out;
		logic        store_valid;
		logic [11:0] store_index;
		logic        read_done;
		logic [11:0] done_count;
		logic [7:0]  requester_out;
	} out_item_t;

	typedef struct packed {
		logic [7:0]  ch;
		logic [11:0] remaining;
		logic [11:0] delivered;
		logic [7:0]  reader;
	} edit_ctx_t;

	typedef struct packed {
		out_item_t   item;
		logic [11:0] remaining;
		logic [11:0] delivered;
	} edit_res_t;

endpackage

// ----- rtl/core/tli_queue_mem.sv -----
// ----------------------------------------------------------------------------
// TTY line input discipline character queue memory
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tli_queue_mem #(
	parameter int QUEUE_DEPTH = 256,
	parameter int AW          = $clog2(QUEUE_DEPTH)
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [7:0]    wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [7:0]    rd_data
);

	logic [7:0] mem [QUEUE_DEPTH];
	logic [7:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ----- rtl/core/tli_edit.sv -----
// ----------------------------------------------------------------------------
// TTY line input discipline line editor
// Applies the editing rules to one popped character and the pending read.
// ----------------------------------------------------------------------------
module tli_edit
	import tli_pkg::*;
(
	input  edit_ctx_t ctx,
	output edit_res_t res
);

	logic        printable;
	logic [11:0] rem_n;
	logic [11:0] del_n;

	assign printable = (ctx.ch >= CH_FIRST_PRINT) && (ctx.ch <= CH_LAST_PRINT);

	always_comb begin
		res                = '0;
		res.item.char_out  = ctx.ch;
		rem_n              = ctx.remaining;
		del_n              = ctx.delivered;
		if (ctx.remaining == 12'd0) begin
			res.item.status = STS_DISCARDED;
		end else begin
			res.item.status = STS_CONSUMED;
			if (printable) begin
				res.item.echo_valid  = 1'b1;
				res.item.store_valid = 1'b1;
				res.item.store_index = ctx.delivered;
				del_n                = ctx.delivered + 12'd1;
				rem_n                = ctx.remaining - 12'd1;
			end else if (ctx.ch == CH_BACKSPACE && ctx.delivered != 12'd0) begin
				res.item.echo_valid = 1'b1;
				del_n               = ctx.delivered - 12'd1;
				rem_n               = ctx.remaining + 12'd1;
			end
			if (ctx.ch == CH_NEWLINE || rem_n == 12'd0) begin
				res.item.echo_valid    = 1'b1;
				res.item.read_done     = 1'b1;
				res.item.done_count    = del_n;
				res.item.requester_out = ctx.reader;
				rem_n                  = 12'd0;
			end
		end
		res.remaining = rem_n;
		res.delivered = del_n;
	end

endmodule

// ----- rtl/core/tty_line_input_discipline.sv -----
// ----------------------------------------------------------------------------
// TTY line input discipline
// Cooked-mode keyboard input: key queue, read arming and line editing.
// ----------------------------------------------------------------------------
//   channel  handshake           payload
//   in       in_valid/in_stall   in_data   (in_item_t)
//   out      out_valid/out_stall out_data  (out_item_t)
//   cfg      cfg_we              cfg_index, cfg_wdata
//
// Key, read, unused and empty-queue service items load the output register
// directly; a popping service item first goes through the queue memory's
// registered read port. Each item gives one result held in an output register;
// the input stalls while that register holds a result that the receiver stalls.
// Reset clears pointers, counts and the pending read and restores the key
// codes to their defaults; the queue memory is not cleared.
module tty_line_input_discipline
	import tli_pkg::*;
#(
	parameter int QUEUE_DEPTH = 256
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_data,
	input  logic      cfg_we,
	input  logic      cfg_index,
	input  logic [8:0] cfg_wdata
);

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	state_t      state_q, state_d;
	logic [8:0]  enter_q, bksp_q;
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic [11:0] remaining_q, delivered_q;
	logic [7:0]  reader_q;
	logic        res_valid_q;
	out_item_t   res_q;

	logic        slot_free, pop_commit, accept, svc_pop, push, res_load, full;
	logic        key_ok;
	logic [7:0]  key_ch, rd_data;
	out_item_t   imm_item;
	edit_ctx_t   ctx;
	edit_res_t   ed;

	assign slot_free = !res_valid_q || !out_stall;
	assign accept    = in_valid && !in_stall;
	assign full      = count_q == CW'(QUEUE_DEPTH);
	assign svc_pop   = accept && in_data.command == CMD_SERVICE && count_q != '0;
	assign push      = accept && in_data.command == CMD_KEY && key_ok && !full;
	assign res_load  = pop_commit || (accept && !svc_pop);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (svc_pop) state_d = S_POP;
			S_POP:  if (slot_free) state_d = S_IDLE;
		endcase
	end

	always_comb begin
		in_stall   = 1'b1;
		pop_commit = 1'b0;
		unique case (state_q)
			S_IDLE: in_stall = !slot_free;
			S_POP:  pop_commit = slot_free;
		endcase
	end

	always_comb begin
		key_ok = 1'b1;
		key_ch = in_data.key_code[7:0];
		priority if (!in_data.key_code[SPECIAL_BIT]) begin
			key_ch = in_data.key_code[7:0];
		end else if (in_data.key_code == enter_q) begin
			key_ch = CH_NEWLINE;
		end else if (in_data.key_code == bksp_q) begin
			key_ch = CH_BACKSPACE;
		end else begin
			key_ok = 1'b0;
		end
	end

	always_comb begin
		imm_item = '0;
		unique case (in_data.command)
			CMD_KEY: begin
				if (!key_ok) imm_item.status = STS_IGNORED;
				else if (full) imm_item.status = STS_DROPPED;
				else imm_item.status = STS_QUEUED;
			end
			CMD_READ:    imm_item.status = STS_ARMED;
			CMD_SERVICE: imm_item.status = STS_EMPTY;
			default:     imm_item.status = STS_IGNORED;
		endcase
	end

	tli_queue_mem #(
		.QUEUE_DEPTH(QUEUE_DEPTH),
		.AW         (AW)
	) u_mem (
		.clk    (clk),
		.wr_en  (push),
		.wr_addr(wr_ptr_q),
		.wr_data(key_ch),
		.rd_en  (svc_pop),
		.rd_addr(rd_ptr_q),
		.rd_data(rd_data)
	);

	assign ctx = '{ch: rd_data, remaining: remaining_q, delivered: delivered_q,
		reader: reader_q};

	tli_edit u_edit (
		.ctx(ctx),
		.res(ed)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enter_q <= ENTER_RESET;
			bksp_q  <= BACKSPACE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ENTER:     enter_q <= cfg_wdata;
				REG_BACKSPACE: bksp_q  <= cfg_wdata;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			wr_ptr_q    <= '0;
			rd_ptr_q    <= '0;
			count_q     <= '0;
			remaining_q <= '0;
			delivered_q <= '0;
			reader_q    <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
				count_q  <= count_q + 1'b1;
			end
			if (svc_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
				count_q  <= count_q - 1'b1;
			end
			if (accept && in_data.command == CMD_READ) begin
				remaining_q <= in_data.request_count;
				delivered_q <= '0;
				reader_q    <= in_data.requester;
			end
			if (pop_commit) begin
				remaining_q <= ed.remaining;
				delivered_q <= ed.delivered;
			end
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (!out_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q <= pop_commit ? ed.item : imm_item;
		end
	end

	assign out_valid = res_valid_q;
	assign out_data  = res_q;

endmodule

// ----- rtl/core/tli_checker.sv -----
// ----------------------------------------------------------------------------
// TTY line input discipline port checker
// Watches the result channel of the top level over time.
// ----------------------------------------------------------------------------
`include "tty_line_input_discipline_assert.svh"

module tli_checker
	import tli_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      out_valid,
	input logic      out_stall,
	input out_item_t out_data
);

	`TLI_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
		out_valid && $stable(out_data), "stalled result changed")
	`TLI_ASSERT_NOW(a_store_echo, out_valid && out_data.store_valid,
		out_data.echo_valid && out_data.status == STS_CONSUMED,
		"store without echo or consume")
	`TLI_ASSERT_NOW(a_done_echo, out_valid && out_data.read_done,
		out_data.echo_valid && out_data.status == STS_CONSUMED,
		"read done without echo or consume")
	`TLI_ASSERT_NOW(a_idle_quiet,
		out_valid && out_data.status != STS_CONSUMED && out_data.status != STS_DISCARDED,
		!out_data.echo_valid && !out_data.store_valid && !out_data.read_done
			&& out_data.char_out == 8'd0,
		"non-service result carries data")

endmodule

bind tty_line_input_discipline tli_checker u_tli_checker (.*);

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// TTY line input discipline testbench
// Drives key, read and service items through the valid/stall channels,
// predicts each result with an in-bench model of the queue and the line
// editor or the directed table, and compares it field by field. The table opens
// the run; random typed lines and noise follow under several key-code
// settings, idle patterns, a long receiver hold-off and a queue flood.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import tli_pkg::*;

	localparam int KQ_DEPTH = 256;
	localparam int QUIET_LIMIT = 2000;
	localparam int HOLD_CYCLES = 80;
	localparam int PHASE_ITEMS = 60;
	localparam int PRINT_CAP = 200;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	typedef struct packed {
		in_item_t  item;
		logic      typed;
		out_item_t want;
	} dir_row_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	in_item_t   in_data = '0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	out_item_t  out_data;
	logic       cfg_we = 1'b0;
	logic       cfg_index = 1'b0;
	logic [8:0] cfg_wdata = '0;

	tty_line_input_discipline #(
		.QUEUE_DEPTH(KQ_DEPTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	logic [7:0]  kq [KQ_DEPTH];
	int          kq_wr = 0;
	int          kq_rd = 0;
	int          kq_count = 0;
	logic [11:0] left_cnt = '0;
	logic [11:0] got_cnt = '0;
	logic [7:0]  reader_id = '0;
	logic [8:0]  enter_code = ENTER_RESET;
	logic [8:0]  bs_code = BACKSPACE_RESET;

	out_item_t cooked_due [$];
	dir_row_t  dir_table [$];
	int        mismatches = 0;
	int        results_seen = 0;
	int        tx_idle_pct = 0;
	int        rx_idle_pct = 0;
	int        hold_asked = 0;
	int        phase_items = 0;

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic in_item_t mk_in(logic [1:0] cmd, logic [8:0] key, logic [11:0] cnt,
			logic [7:0] who);
		in_item_t it;
		it.command = cmd;
		it.key_code = key;
		it.request_count = cnt;
		it.requester = who;
		return it;
	endfunction

	function automatic in_item_t rand_item(logic [1:0] cmd);
		in_item_t it;
		it.command = cmd;
		it.key_code = 9'($urandom);
		it.request_count = 12'($urandom);
		it.requester = 8'($urandom);
		return it;
	endfunction

	function automatic out_item_t bare_result(logic [2:0] status, logic [7:0] ch);
		out_item_t r;
		r = '0;
		r.status = status;
		r.char_out = ch;
		return r;
	endfunction

	function automatic logic [2:0] push_key(logic [7:0] ch);
		if (kq_count >= KQ_DEPTH) return STS_DROPPED;
		kq[kq_wr] = ch;
		kq_wr = (kq_wr + 1) % KQ_DEPTH;
		kq_count++;
		return STS_QUEUED;
	endfunction

	function automatic out_item_t cook_item(in_item_t it);
		out_item_t  r;
		logic [7:0] ch;
		r = '0;
		r.status = STS_IGNORED;
		case (it.command)
			CMD_KEY: begin
				if (!it.key_code[SPECIAL_BIT]) r.status = push_key(it.key_code[7:0]);
				else if (it.key_code == enter_code) r.status = push_key(CH_NEWLINE);
				else if (it.key_code == bs_code) r.status = push_key(CH_BACKSPACE);
			end
			CMD_READ: begin
				left_cnt = it.request_count;
				got_cnt = '0;
				reader_id = it.requester;
				r.status = STS_ARMED;
			end
			CMD_SERVICE: begin
				if (kq_count == 0) begin
					r.status = STS_EMPTY;
				end else begin
					ch = kq[kq_rd];
					kq_rd = (kq_rd + 1) % KQ_DEPTH;
					kq_count--;
					r.char_out = ch;
					if (left_cnt == 0) begin
						r.status = STS_DISCARDED;
					end else begin
						r.status = STS_CONSUMED;
						if (ch >= CH_FIRST_PRINT && ch <= CH_LAST_PRINT) begin
							r.echo_valid = 1'b1;
							r.store_valid = 1'b1;
							r.store_index = got_cnt;
							got_cnt = got_cnt + 12'd1;
							left_cnt = left_cnt - 12'd1;
						end else if (ch == CH_BACKSPACE && got_cnt != 0) begin
							r.echo_valid = 1'b1;
							got_cnt = got_cnt - 12'd1;
							left_cnt = left_cnt + 12'd1;
						end
						if (ch == CH_NEWLINE || left_cnt == 0) begin
							r.echo_valid = 1'b1;
							r.read_done = 1'b1;
							r.done_count = got_cnt;
							r.requester_out = reader_id;
							left_cnt = '0;
						end
					end
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic logic [8:0] pick_key();
		int k;
		k = $urandom_range(0, 99);
		if (k < 65) return 9'($urandom_range(CH_FIRST_PRINT, CH_LAST_PRINT));
		if (k < 80) return bs_code;
		if (k < 88) return 9'($urandom_range(0, 255));
		if (k < 94) return 9'($urandom_range(256, 511));
		return enter_code;
	endfunction

	task automatic flag(string msg);
		mismatches++;
		if (mismatches <= PRINT_CAP) $display("mismatch: %s", msg);
	endtask

	task automatic check_field(string name, logic [11:0] got, logic [11:0] want);
		if (got !== want)
			flag($sformatf("result %0d %s got %0h want %0h", results_seen, name, got, want));
	endtask

	task automatic send_item(in_item_t it, logic typed = 1'b0, out_item_t want = '0);
		out_item_t got;
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		got = cook_item(it);
		cooked_due.push_back(typed ? want : got);
		phase_items++;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (cooked_due.size() != 0) @(posedge clk);
	endtask

	task automatic set_codes(logic [8:0] enter, logic [8:0] bs);
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= REG_ENTER;
		cfg_wdata <= enter;
		@(posedge clk);
		cfg_index <= REG_BACKSPACE;
		cfg_wdata <= bs;
		@(posedge clk);
		cfg_we <= 1'b0;
		enter_code = enter;
		bs_code = bs;
	endtask

	task automatic type_line();
		in_item_t it;
		int       n;
		it = rand_item(CMD_READ);
		case ($urandom_range(0, 9))
			0: it.request_count = '0;
			1: it.request_count = 12'hFFF;
			2: it.request_count = 12'($urandom_range(0, 4095));
			default: it.request_count = 12'($urandom_range(1, 12));
		endcase
		send_item(it);
		n = $urandom_range(0, 10);
		repeat (n) begin
			it = rand_item(CMD_KEY);
			it.key_code = pick_key();
			send_item(it);
		end
		if ($urandom_range(0, 9) < 7) begin
			it = rand_item(CMD_KEY);
			it.key_code = enter_code;
			send_item(it);
			n++;
		end
		repeat (n + 1 + $urandom_range(0, 2)) send_item(rand_item(CMD_SERVICE));
	endtask

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
			else quiet++;
		end
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		int        hold_left;
		int        hold_done;
		out_item_t want;
		hold_left = 0;
		hold_done = 0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				results_seen++;
				if (cooked_due.size() == 0) begin
					flag($sformatf("result %0d arrived with nothing due", results_seen));
				end else begin
					want = cooked_due.pop_front();
					check_field("status", 12'(out_data.status), 12'(want.status));
					check_field("echo_valid", 12'(out_data.echo_valid),
						12'(want.echo_valid));
					check_field("char_out", 12'(out_data.char_out), 12'(want.char_out));
					check_field("store_valid", 12'(out_data.store_valid),
						12'(want.store_valid));
					check_field("store_index", out_data.store_index, want.store_index);
					check_field("read_done", 12'(out_data.read_done),
						12'(want.read_done));
					check_field("done_count", out_data.done_count, want.done_count);
					check_field("requester_out", 12'(out_data.requester_out),
						12'(want.requester_out));
				end
			end
			if (hold_asked != hold_done) begin
				hold_left = HOLD_CYCLES;
				hold_done = hold_asked;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
			end
		end
	end

	initial begin
		in_item_t it;
		dir_table.push_back({mk_in(CMD_SERVICE, 9'h000, 12'h000, 8'h00), 1'b1,
			bare_result(STS_EMPTY, 8'h00)});
		dir_table.push_back({mk_in(CMD_UNUSED, 9'h1FF, 12'hFFF, 8'hFF), 1'b1,
			bare_result(STS_IGNORED, 8'h00)});
		dir_table.push_back({mk_in(CMD_KEY, 9'h1FF, 12'h000, 8'h00), 1'b1,
			bare_result(STS_IGNORED, 8'h00)});
		dir_table.push_back({mk_in(CMD_KEY, 9'h000, 12'hFFF, 8'hFF), 1'b1,
			bare_result(STS_QUEUED, 8'h00)});
		dir_table.push_back({mk_in(CMD_SERVICE, 9'h1FF, 12'hFFF, 8'hFF), 1'b1,
			bare_result(STS_DISCARDED, 8'h00)});
		dir_table.push_back({mk_in(CMD_READ, 9'h000, 12'h000, 8'hFF), 1'b1,
			bare_result(STS_ARMED, 8'h00)});
		dir_table.push_back({mk_in(CMD_KEY, 9'h041, 12'h000, 8'h00), 1'b1,
			bare_result(STS_QUEUED, 8'h00)});
		dir_table.push_back({mk_in(CMD_SERVICE, 9'h000, 12'h000, 8'h00), 1'b1,
			bare_result(STS_DISCARDED, 8'h41)});
		dir_table.push_back({mk_in(CMD_READ, 9'h000, 12'hFFF, 8'hAA), 1'b1,
			bare_result(STS_ARMED, 8'h00)});
		dir_table.push_back({mk_in(CMD_KEY, 9'h0FF, 12'h000, 8'h00), 1'b1,
			bare_result(STS_QUEUED, 8'h00)});
		dir_table.push_back({mk_in(CMD_KEY, 9'h020, 12'h000, 8'h00), 1'b1,
			bare_result(STS_QUEUED, 8'h00)});
		dir_table.push_back({mk_in(CMD_KEY, 9'h07E, 12'h000, 8'h00), 1'b1,
			bare_result(STS_QUEUED, 8'h00)});
		dir_table.push_back({mk_in(CMD_KEY, 9'h01F, 12'h000, 8'h00), 1'b1,
			bare_result(STS_QUEUED, 8'h00)});
		repeat (3) dir_table.push_back({mk_in(CMD_KEY, BACKSPACE_RESET, 12'h000, 8'h00), 1'b1,
			bare_result(STS_QUEUED, 8'h00)});
		dir_table.push_back({mk_in(CMD_KEY, ENTER_RESET, 12'h000, 8'h00), 1'b1,
			bare_result(STS_QUEUED, 8'h00)});
		repeat (8) dir_table.push_back({mk_in(CMD_SERVICE, 9'h000, 12'h000, 8'h00), 1'b0,
			out_item_t'('0)});
		dir_table.push_back({mk_in(CMD_READ, 9'h000, 12'd5, 8'h11), 1'b1,
			bare_result(STS_ARMED, 8'h00)});
		dir_table.push_back({mk_in(CMD_READ, 9'h000, 12'd1, 8'h22), 1'b1,
			bare_result(STS_ARMED, 8'h00)});
		dir_table.push_back({mk_in(CMD_KEY, 9'h07A, 12'h000, 8'h00), 1'b1,
			bare_result(STS_QUEUED, 8'h00)});
		dir_table.push_back({mk_in(CMD_SERVICE, 9'h000, 12'h000, 8'h00), 1'b0,
			out_item_t'('0)});

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tx_idle_pct = 15;
		rx_idle_pct = 51;
		foreach (dir_table[i]) send_item(dir_table[i].item, dir_table[i].typed, dir_table[i].want);

		for (int ph = 0; ph < 4; ph++) begin
			wait_drained();
			case (ph)
				0: set_codes(9'd256, 9'd511);
				1: set_codes(9'd511, 9'd256);
				2: set_codes(9'd300, 9'd300);
				default: set_codes(9'($urandom_range(256, 511)), 9'($urandom_range(256, 511)));
			endcase
			if (ph == 2) begin
				tx_idle_pct = 51;
				rx_idle_pct = 15;
			end else if (ph == 3) begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			phase_items = 0;
			while (phase_items < PHASE_ITEMS) begin
				if ($urandom_range(0, 99) < 80) type_line();
				else send_item(rand_item(2'($urandom_range(0, 3))));
			end
		end

		// hold the sender until all results are in, then flood the queue past full
		wait_drained();
		hold_asked++;
		@(posedge clk);
		repeat (KQ_DEPTH - kq_count + 4) begin
			it = rand_item(CMD_KEY);
			it.key_code[SPECIAL_BIT] = 1'b0;
			send_item(it);
		end
		type_line();

		wait_drained();
		repeat (10) @(posedge clk);
		if (mismatches == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

// ----- tty_line_input_discipline.f -----
+incdir+rtl/core
rtl/core/tli_pkg.sv
rtl/core/tli_queue_mem.sv
rtl/core/tli_edit.sv
rtl/core/tty_line_input_discipline.sv
rtl/core/tli_checker.sv
tb/sv/testbench.sv
